/* hw/rtl/vlq_pkg.sv */
`timescale 1ns / 1ps

package vlq_pkg;

   // Operation codes of the request beat.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_LATENCY  = 2'd0;
   localparam logic [1:0] KIND_RELEASED = 2'd1;
   localparam logic [1:0] KIND_DROPPED  = 2'd2;

   // Register indexes on the csr port.
   localparam logic [2:0] REG_LAT_VENUE_ZERO  = 3'd0;
   localparam logic [2:0] REG_LAT_VENUE_ONE   = 3'd1;
   localparam logic [2:0] REG_LAT_VENUE_TWO   = 3'd2;
   localparam logic [2:0] REG_LAT_VENUE_THREE = 3'd3;
   localparam logic [2:0] REG_DEFAULT_LAT     = 3'd4;
   localparam logic [2:0] REG_POLL_INTERVAL   = 3'd5;

   // Register reset values.
   localparam logic [15:0] RST_LAT_VENUE_ZERO  = 16'd20;
   localparam logic [15:0] RST_LAT_VENUE_ONE   = 16'd70;
   localparam logic [15:0] RST_LAT_VENUE_TWO   = 16'd15;
   localparam logic [15:0] RST_LAT_VENUE_THREE = 16'd25;
   localparam logic [15:0] RST_DEFAULT_LAT     = 16'd50;
   localparam logic [9:0]  RST_POLL_INTERVAL   = 10'd1;

   // Most releases one tick may produce.
   localparam int MAX_RESULTS = 16;
   localparam int NW          = $clog2(MAX_RESULTS + 1);

   // Cell load selects.
   localparam logic [1:0] SEL_HOLD  = 2'd0;
   localparam logic [1:0] SEL_SHIFT = 2'd1;
   localparam logic [1:0] SEL_TAIL  = 2'd2;
   localparam logic [1:0] SEL_ADD   = 2'd3;

   typedef struct packed {
      logic [15:0] tag;
      logic [31:0] deadline;
   } entry_type;

endpackage

/* hw/rtl/vlq_cell.sv */
`timescale 1ns / 1ps

module vlq_cell
   import vlq_pkg::*;
(
   input  logic       clock,
   input  logic [1:0] sel,
   input  entry_type  right_in,
   input  entry_type  head_in,
   input  entry_type  add_in,
   output entry_type  data_out
);

   entry_type data_ff;

   // Hold, take the neighbor's entry, take the recirculated head, or take a new entry.
   always_ff @(posedge clock) begin
      unique case (sel)
         SEL_HOLD:  data_ff <= data_ff;
         SEL_SHIFT: data_ff <= right_in;
         SEL_TAIL:  data_ff <= head_in;
         SEL_ADD:   data_ff <= add_in;
      endcase
   end

   assign data_out = data_ff;

endmodule

/* hw/rtl/venue_latency_delay_queue.sv */
`timescale 1ns / 1ps
// Timed delay queue for orders routed to one of four venues.
// Request channel: an item is taken at a rising edge with start high and busy
// low. req_operation selects an add (tag plus venue) or a tick of one poll
// interval. Result channel: rsp_valid strobes for one cycle per result beat;
// the receiver cannot stall, so every beat must be taken when shown.
// Configuration: csr_we writes csr_wdata into register csr_index at once;
// indexes above 5 are ignored. Write only while busy is low and no beat pends.
// Adds: an add answers in the cycle after it is taken with a latency event,
// or a dropped beat when the store is full; adds leave busy low, so outside
// a tick scan they go back to back at one per cycle. A tick advances the
// millisecond clock and walks the entry chain from its head, one stored
// entry per cycle, holding busy until the scan closes; releases follow in
// insertion order, the final one marked by rsp_last. The chain of cells
// sets this pace: cell 0 is the only one examined.
// Reset clears the clock, the entry count and the registers to their
// defaults; the entry cells themselves are not cleared.
module venue_latency_delay_queue
   import vlq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [15:0] req_order_tag,
   input  logic [2:0]  req_venue,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_tag_out,
   output logic [15:0] rsp_latency_out,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // ---------------- configuration registers ----------------
   logic [15:0] lat0_ff, lat1_ff, lat2_ff, lat3_ff, lat_def_ff;
   logic [9:0]  poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat0_ff    <= RST_LAT_VENUE_ZERO;
         lat1_ff    <= RST_LAT_VENUE_ONE;
         lat2_ff    <= RST_LAT_VENUE_TWO;
         lat3_ff    <= RST_LAT_VENUE_THREE;
         lat_def_ff <= RST_DEFAULT_LAT;
         poll_ff    <= RST_POLL_INTERVAL;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LAT_VENUE_ZERO:  lat0_ff    <= csr_wdata;
            REG_LAT_VENUE_ONE:   lat1_ff    <= csr_wdata;
            REG_LAT_VENUE_TWO:   lat2_ff    <= csr_wdata;
            REG_LAT_VENUE_THREE: lat3_ff    <= csr_wdata;
            REG_DEFAULT_LAT:     lat_def_ff <= csr_wdata;
            REG_POLL_INTERVAL:   poll_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // ---------------- control state ----------------
   logic          state_ff, state_in;
   logic [31:0]   now_ff, now_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [NW-1:0] rel_ff, rel_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [15:0]   pend_tag_ff, pend_tag_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [15:0]   rsp_tag_ff, rsp_tag_in;
   logic [15:0]   rsp_lat_ff, rsp_lat_in;
   logic          rsp_last_ff, rsp_last_in;

   logic accept, do_add, do_tick, full, scan_step, scan_done, head_due, release_head;
   logic [15:0] venue_lat;

   entry_type cell_q [DEPTH];
   entry_type add_entry;

   assign busy      = (state_ff == ST_SCAN);
   assign accept    = start && !busy;
   assign do_add    = accept && (req_operation == OP_ADD);
   assign do_tick   = accept && (req_operation == OP_TICK);
   assign full      = (count_ff == CW'(DEPTH));
   assign scan_step = busy && (remain_ff != '0);
   assign scan_done = busy && (remain_ff == '0);

   // Due when the head deadline is not ahead of now, modulo 2^32.
   assign head_due     = ((now_ff - cell_q[0].deadline) >> 31) == 32'd0;
   assign release_head = scan_step && head_due && (rel_ff != NW'(MAX_RESULTS));

   always_comb begin
      unique case (req_venue)
         3'd0:    venue_lat = lat0_ff;
         3'd1:    venue_lat = lat1_ff;
         3'd2:    venue_lat = lat2_ff;
         3'd3:    venue_lat = lat3_ff;
         default: venue_lat = lat_def_ff;
      endcase
   end

   assign add_entry.tag      = req_order_tag;
   assign add_entry.deadline = now_ff + {16'd0, venue_lat};

   // ---------------- cell chain ----------------
   // During a scan the live window 0..count-1 acts as a queue: every cell
   // advances toward the head, and a kept head re-enters at the window tail.
   // A released head simply shrinks the window.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type  right_d;
      logic [1:0] sel_d;

      if (i < DEPTH - 1) begin : g_mid
         assign right_d = cell_q[i+1];
      end else begin : g_end
         assign right_d = cell_q[0];
      end

      always_comb begin
         sel_d = SEL_HOLD;
         if (scan_step) begin
            if (CW'(i + 1) < count_ff) begin
               sel_d = SEL_SHIFT;
            end else if ((CW'(i + 1) == count_ff) && !release_head) begin
               sel_d = SEL_TAIL;
            end
         end else if (do_add && !full && (CW'(i) == count_ff)) begin
            sel_d = SEL_ADD;
         end
      end

      vlq_cell u_cell (
         .clock    (clock),
         .sel      (sel_d),
         .right_in (right_d),
         .head_in  (cell_q[0]),
         .add_in   (add_entry),
         .data_out (cell_q[i])
      );
   end

   // ---------------- sequencing ----------------
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rel_in        = rel_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;

      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_RELEASED;
      rsp_tag_in   = pend_tag_ff;
      rsp_lat_in   = 16'd0;
      rsp_last_in  = 1'b0;

      if (do_add) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = req_order_tag;
         rsp_last_in  = 1'b1;
         if (full) begin
            rsp_kind_in = KIND_DROPPED;
         end else begin
            rsp_kind_in = KIND_LATENCY;
            rsp_lat_in  = venue_lat;
            count_in    = count_ff + CW'(1);
         end
      end

      if (do_tick) begin
         now_in        = now_ff + {22'd0, poll_ff};
         state_in      = ST_SCAN;
         remain_in     = count_ff;
         rel_in        = '0;
         pend_valid_in = 1'b0;
      end

      if (scan_step) begin
         remain_in = remain_ff - CW'(1);
         if (release_head) begin
            // Hold the newest release back until we know whether it is the last.
            count_in      = count_ff - CW'(1);
            rel_in        = rel_ff + NW'(1);
            pend_valid_in = 1'b1;
            pend_tag_in   = cell_q[0].tag;
            rsp_valid_in  = pend_valid_ff;
         end
      end

      if (scan_done) begin
         state_in      = ST_IDLE;
         pend_valid_in = 1'b0;
         rsp_valid_in  = pend_valid_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= 32'd0;
         count_ff      <= '0;
         remain_ff     <= '0;
         rel_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         rel_ff        <= rel_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_tag_ff <= pend_tag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_lat_ff  <= rsp_lat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_latency_out = rsp_lat_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      do_add |=> (rsp_valid && rsp_last && (rsp_kind != KIND_RELEASED)))
      else $error("add beat without a final answer");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> !busy)
      else $error("scan did not return to idle");

   a_release_bound: assert property (@(posedge clock) disable iff (reset)
      rel_ff <= NW'(MAX_RESULTS))
      else $error("too many releases in one tick");

   a_no_release_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !(rsp_valid && (rsp_kind == KIND_RELEASED)))
      else $error("release beat outside a scan");

endmodule
